// ===== rtl/point_plane_distance_3d_unit_macros.svh =====
// Assertion macros for the point-to-plane distance unit.
`ifndef POINT_PLANE_DISTANCE_3D_UNIT_MACROS_SVH
`define POINT_PLANE_DISTANCE_3D_UNIT_MACROS_SVH
`ifndef SYNTH
`define PPD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("ppd assertion failed");
`define PPD_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("ppd reset assertion failed");
`else
`define PPD_ASSERT(lbl, prop)
`define PPD_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== rtl/ppd_pkg.sv =====
// Types and widths shared by the point-to-plane distance unit.
package ppd_pkg;

    localparam int CRD_W  = 16;   // input coordinate, Q12.4
    localparam int EDGE_W = 17;   // edge and offset vectors
    localparam int NRM_W  = 35;   // normal components
    localparam int SP_W   = 53;   // one term of the plane offset
    localparam int S_W    = 54;   // plane offset sum
    localparam int SM_W   = 52;   // offset magnitude
    localparam int HALF_W = 26;   // half of the magnitude for split multiply
    localparam int NN_W   = 70;   // squared normal length
    localparam int T_W    = 112;  // 256 * S^2
    localparam int Q_W    = 42;   // quotient floor(T / |N|^2)
    localparam int R_W    = 21;   // distance

    typedef struct packed {
        logic signed [CRD_W-1:0] a_x;
        logic signed [CRD_W-1:0] a_y;
        logic signed [CRD_W-1:0] a_z;
        logic signed [CRD_W-1:0] b_x;
        logic signed [CRD_W-1:0] b_y;
        logic signed [CRD_W-1:0] b_z;
        logic signed [CRD_W-1:0] c_x;
        logic signed [CRD_W-1:0] c_y;
        logic signed [CRD_W-1:0] c_z;
        logic signed [CRD_W-1:0] p_x;
        logic signed [CRD_W-1:0] p_y;
        logic signed [CRD_W-1:0] p_z;
    } t_in_word;

    typedef struct packed {
        logic [R_W-1:0] distance;
        logic           degenerate;
    } t_out_word;

    typedef struct packed {
        logic valid;
        logic degen;
        logic sat;
    } t_ctl;

endpackage

// ===== rtl/ppd_front.sv =====
// Front stages: edges, normal, offset, squared length, 256*S^2 and saturation test.
module ppd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  ppd_pkg::t_in_word   i_word,
    output ppd_pkg::t_ctl       o_ctl,
    output logic [ppd_pkg::T_W-1:0]  o_t,
    output logic [ppd_pkg::NN_W-1:0] o_nn
);
    import ppd_pkg::*;

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    logic r_dg5, r_dg6, r_dg7;
    t_ctl r_ctl8;

    logic signed [EDGE_W-1:0] r1_ux, r1_uy, r1_uz, r1_vx, r1_vy, r1_vz;
    logic signed [EDGE_W-1:0] r1_dx, r1_dy, r1_dz;
    logic signed [NRM_W-1:0]  r2_nx, r2_ny, r2_nz;
    logic signed [EDGE_W-1:0] r2_dx, r2_dy, r2_dz;
    logic signed [SP_W-1:0]   r3_sx, r3_sy, r3_sz;
    logic signed [NN_W-1:0]   r3_qx, r3_qy, r3_qz;
    logic signed [S_W-1:0]    r4_s;
    logic [NN_W-1:0]          r4_nn, r5_nn, r6_nn, r7_nn, r8_nn;
    logic [SM_W-1:0]          r5_sm;
    logic [2*HALF_W-1:0]      r6_hh, r6_hl, r6_ll;
    logic [T_W-1:0]           r7_t, r8_t;
    logic signed [S_W-1:0]    n_sm;

    assign n_sm = r4_s[S_W-1] ? -r4_s : r4_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0;
            r_v5 <= 1'b0; r_v6 <= 1'b0; r_v7 <= 1'b0;
            r_dg5 <= 1'b0; r_dg6 <= 1'b0; r_dg7 <= 1'b0;
            r_ctl8 <= '0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            r_dg5 <= (r4_nn == '0);
            r_dg6 <= r_dg5;
            r_dg7 <= r_dg6;
            r_ctl8.valid <= r_v7;
            r_ctl8.degen <= r_dg7;
            // quotient would reach 2^42, so the root would pass 2^21-1
            r_ctl8.sat   <= !r_dg7 && (r7_t >= (T_W'(r7_nn) << Q_W));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ux <= EDGE_W'(i_word.b_x) - EDGE_W'(i_word.a_x);
            r1_uy <= EDGE_W'(i_word.b_y) - EDGE_W'(i_word.a_y);
            r1_uz <= EDGE_W'(i_word.b_z) - EDGE_W'(i_word.a_z);
            r1_vx <= EDGE_W'(i_word.c_x) - EDGE_W'(i_word.a_x);
            r1_vy <= EDGE_W'(i_word.c_y) - EDGE_W'(i_word.a_y);
            r1_vz <= EDGE_W'(i_word.c_z) - EDGE_W'(i_word.a_z);
            r1_dx <= EDGE_W'(i_word.p_x) - EDGE_W'(i_word.a_x);
            r1_dy <= EDGE_W'(i_word.p_y) - EDGE_W'(i_word.a_y);
            r1_dz <= EDGE_W'(i_word.p_z) - EDGE_W'(i_word.a_z);

            r2_nx <= NRM_W'(r1_uy) * NRM_W'(r1_vz) - NRM_W'(r1_uz) * NRM_W'(r1_vy);
            r2_ny <= NRM_W'(r1_uz) * NRM_W'(r1_vx) - NRM_W'(r1_ux) * NRM_W'(r1_vz);
            r2_nz <= NRM_W'(r1_ux) * NRM_W'(r1_vy) - NRM_W'(r1_uy) * NRM_W'(r1_vx);
            r2_dx <= r1_dx;
            r2_dy <= r1_dy;
            r2_dz <= r1_dz;

            r3_sx <= SP_W'(r2_nx) * SP_W'(r2_dx);
            r3_sy <= SP_W'(r2_ny) * SP_W'(r2_dy);
            r3_sz <= SP_W'(r2_nz) * SP_W'(r2_dz);
            r3_qx <= NN_W'(r2_nx) * NN_W'(r2_nx);
            r3_qy <= NN_W'(r2_ny) * NN_W'(r2_ny);
            r3_qz <= NN_W'(r2_nz) * NN_W'(r2_nz);

            r4_s  <= S_W'(r3_sx) + S_W'(r3_sy) + S_W'(r3_sz);
            r4_nn <= NN_W'(r3_qx) + NN_W'(r3_qy) + NN_W'(r3_qz);

            r5_sm <= n_sm[SM_W-1:0];
            r5_nn <= r4_nn;

            r6_hh <= (2*HALF_W)'(r5_sm[SM_W-1:HALF_W]) * (2*HALF_W)'(r5_sm[SM_W-1:HALF_W]);
            r6_hl <= (2*HALF_W)'(r5_sm[SM_W-1:HALF_W]) * (2*HALF_W)'(r5_sm[HALF_W-1:0]);
            r6_ll <= (2*HALF_W)'(r5_sm[HALF_W-1:0]) * (2*HALF_W)'(r5_sm[HALF_W-1:0]);
            r6_nn <= r5_nn;

            // 256 * (hh*2^52 + 2*hl*2^26 + ll)
            r7_t  <= (T_W'(r6_hh) << (2*HALF_W + 8)) + (T_W'(r6_hl) << (HALF_W + 9))
                   + (T_W'(r6_ll) << 8);
            r7_nn <= r6_nn;

            r8_t  <= r7_t;
            r8_nn <= r7_nn;
        end
    end

    assign o_ctl = r_ctl8;
    assign o_t   = r8_t;
    assign o_nn  = r8_nn;

endmodule

// ===== rtl/ppd_div.sv =====
// Restoring divider, one quotient bit per pipeline stage: q = floor(T / |N|^2).
module ppd_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  ppd_pkg::t_ctl            i_ctl,
    input  logic [ppd_pkg::T_W-1:0]  i_t,
    input  logic [ppd_pkg::NN_W-1:0] i_nn,
    output ppd_pkg::t_ctl            o_ctl,
    output logic [ppd_pkg::Q_W-1:0]  o_q
);
    import ppd_pkg::*;

    t_ctl            w_ctl [0:Q_W];
    logic [T_W-1:0]  w_rem [0:Q_W];
    logic [NN_W-1:0] w_nn  [0:Q_W];
    logic [Q_W-1:0]  w_q   [0:Q_W];

    assign w_ctl[0] = i_ctl;
    assign w_rem[0] = i_t;
    assign w_nn[0]  = i_nn;
    assign w_q[0]   = '0;

    for (genvar j = 1; j <= Q_W; j++) begin : g_stage
        localparam int K = Q_W - j;
        t_ctl            r_ctl;
        logic [T_W-1:0]  r_rem;
        logic [NN_W-1:0] r_nn;
        logic [Q_W-1:0]  r_q;
        logic [T_W:0]    n_diff;

        assign n_diff = {1'b0, w_rem[j-1]} - ((T_W+1)'(w_nn[j-1]) << K);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl <= '0;
            end else if (i_en) begin
                r_ctl <= w_ctl[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= n_diff[T_W] ? w_rem[j-1] : n_diff[T_W-1:0];
                r_q   <= {w_q[j-1][Q_W-2:0], !n_diff[T_W]};
                r_nn  <= w_nn[j-1];
            end
        end

        assign w_ctl[j] = r_ctl;
        assign w_rem[j] = r_rem;
        assign w_nn[j]  = r_nn;
        assign w_q[j]   = r_q;
    end

    assign o_ctl = w_ctl[Q_W];
    assign o_q   = w_q[Q_W];

endmodule

// ===== rtl/ppd_isqrt.sv =====
// Integer square root, one result bit per pipeline stage.
module ppd_isqrt (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  ppd_pkg::t_ctl           i_ctl,
    input  logic [ppd_pkg::Q_W-1:0] i_q,
    output ppd_pkg::t_ctl           o_ctl,
    output logic [ppd_pkg::R_W-1:0] o_root
);
    import ppd_pkg::*;

    t_ctl           w_ctl [0:R_W];
    logic [Q_W-1:0] w_rem [0:R_W];
    logic [R_W-1:0] w_r   [0:R_W];

    assign w_ctl[0] = i_ctl;
    assign w_rem[0] = i_q;
    assign w_r[0]   = '0;

    for (genvar j = 1; j <= R_W; j++) begin : g_stage
        localparam int B = R_W - j;
        t_ctl           r_ctl;
        logic [Q_W-1:0] r_rem;
        logic [R_W-1:0] r_r;
        logic [Q_W:0]   n_trial;
        logic [Q_W:0]   n_diff;

        // (r + 2^b)^2 - r^2
        assign n_trial = ((Q_W+1)'(w_r[j-1]) << (B + 1)) + ((Q_W+1)'(1) << (2 * B));
        assign n_diff  = {1'b0, w_rem[j-1]} - n_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl <= '0;
            end else if (i_en) begin
                r_ctl <= w_ctl[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= n_diff[Q_W] ? w_rem[j-1] : n_diff[Q_W-1:0];
                r_r   <= n_diff[Q_W] ? w_r[j-1] : (w_r[j-1] | (R_W'(1) << B));
            end
        end

        assign w_ctl[j] = r_ctl;
        assign w_rem[j] = r_rem;
        assign w_r[j]   = r_r;
    end

    assign o_ctl  = w_ctl[R_W];
    assign o_root = w_r[R_W];

endmodule

// ===== rtl/point_plane_distance_3d_unit.sv =====
// Top level of the point-to-plane distance unit.
// Pipeline from input acceptance to output valid: 8 front stages,
// 42 divider stages, 21 root stages and an output register.
// Throughput: one word per cycle unless stalled; the whole pipeline advances together and holds on a stall.
// Reset: synchronous active-low reset clears all stage valid bits; no clearing pass.
module point_plane_distance_3d_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ppd_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ppd_pkg::t_out_word o_out_word
);
    import ppd_pkg::*;

`include "point_plane_distance_3d_unit_macros.svh"

    logic            w_en;
    t_ctl            w_fr_ctl, w_dv_ctl, w_sq_ctl;
    logic [T_W-1:0]  w_t;
    logic [NN_W-1:0] w_nn;
    logic [Q_W-1:0]  w_q;
    logic [R_W-1:0]  w_root;
    logic            r_out_valid;
    t_out_word       r_out_word;

    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    ppd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_word  (i_in_word),
        .o_ctl   (w_fr_ctl),
        .o_t     (w_t),
        .o_nn    (w_nn)
    );

    ppd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_fr_ctl),
        .i_t     (w_t),
        .i_nn    (w_nn),
        .o_ctl   (w_dv_ctl),
        .o_q     (w_q)
    );

    ppd_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_dv_ctl),
        .i_q     (w_q),
        .o_ctl   (w_sq_ctl),
        .o_root  (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_sq_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_word.degenerate <= w_sq_ctl.degen;
            if (w_sq_ctl.degen) begin
                r_out_word.distance <= '0;
            end else if (w_sq_ctl.sat) begin
                r_out_word.distance <= '1;
            end else begin
                r_out_word.distance <= w_root;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `PPD_ASSERT(a_degen_zero, o_out_valid && o_out_word.degenerate |-> o_out_word.distance == 0)
    `PPD_ASSERT(a_sat_not_degen, w_sq_ctl.valid |-> !(w_sq_ctl.sat && w_sq_ctl.degen))
    `PPD_ASSERT_RST(a_reset_clears, !i_rst_n |=> !o_out_valid && !w_fr_ctl.valid)

endmodule
